[rtl/pie_pkg.sv]
// Package for the postfix integer evaluator.
// Holds the stack sizing constants, character codes, status codes and the
// command word that passes from the front end to the execution unit.
`timescale 1ns / 1ps

package pie_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DATA_W      = 32;
	localparam int DEPTH_OUT_W = 7;
	localparam int DEPTH_MAX   = (1 << DEPTH_OUT_W) - 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS   = DATA_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_UNDER = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_OVF   = 3'd4;

	typedef enum logic [2:0] {
		K_NONE = 3'd0,
		K_ADD  = 3'd1,
		K_SUB  = 3'd2,
		K_MUL  = 3'd3,
		K_DIV  = 3'd4,
		K_END  = 3'd5
	} cmd_kind_t;

	// One queued command: an optional number to push, then an operation.
	typedef struct packed {
		logic              has_push;
		logic [DATA_W-1:0] num;
		cmd_kind_t         kind;
	} cmd_t;

endpackage

[rtl/pie_front.sv]
// Front end of the postfix evaluator: accepts characters, builds numbers
// from digit runs and turns everything else into queued commands.
// Depends on pie_pkg.
`timescale 1ns / 1ps

module pie_front
	import pie_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_data
);

	logic [DATA_W-1:0] acc_q;
	logic              in_num_q;
	logic              accept;
	logic              is_digit;
	cmd_kind_t         kind;
	logic [DATA_W-1:0] acc_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_digit = ch inside {[CH_ZERO:CH_NINE]};
		case (ch)
			CH_PLUS:  kind = K_ADD;
			CH_MINUS: kind = K_SUB;
			CH_STAR:  kind = K_MUL;
			CH_SLASH: kind = K_DIV;
			CH_NUL:   kind = K_END;
			default:  kind = K_NONE;
		endcase
	end

	// Times ten as two shifted copies, wrapping at 32 bits.
	assign acc_next = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0}
		+ DATA_W'(ch[3:0]);

	assign q_push = accept && !is_digit && (in_num_q || kind != K_NONE);
	assign q_data = '{has_push: in_num_q, num: acc_q, kind: kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			in_num_q <= 1'b0;
		end else if (accept) begin
			if (is_digit) begin
				acc_q    <= acc_next;
				in_num_q <= 1'b1;
			end else begin
				acc_q    <= '0;
				in_num_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/pie_queue.sv]
// Small command queue between the front end and the execution unit.
// Depends on pie_pkg for the command word and the queue depth.
`timescale 1ns / 1ps

module pie_queue
	import pie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/pie_back.sv]
// Execution unit of the postfix evaluator: owns the operand stack memory,
// runs pushes and operators, divides one quotient bit per cycle and
// drives the result register. Depends on pie_pkg.
`timescale 1ns / 1ps

module pie_back
	import pie_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  cmd_t                       q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DATA_W-1:0]   value,
	output logic [2:0]                 status,
	output logic [DEPTH_OUT_W-1:0]     depth_left
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_PUSH   = 11'b000_0000_0010,
		S_DISP   = 11'b000_0000_0100,
		S_RD_B   = 11'b000_0000_1000,
		S_RD_A   = 11'b000_0001_0000,
		S_EXEC   = 11'b000_0010_0000,
		S_DIV    = 11'b000_0100_0000,
		S_DFIX   = 11'b000_1000_0000,
		S_WB     = 11'b001_0000_0000,
		S_RD_END = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t            state_q;
	logic [SP_W-1:0]   sp_q;
	logic [2:0]        err_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic              we;

	logic              stack_full;
	logic [DATA_W:0]   trial;
	logic              fits;
	logic [DATA_W-1:0] sp_wide;
	logic              out_free;

	assign stack_full = sp_q >= SP_W'(STACK_DEPTH);
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign out_free   = !out_valid || out_ready;
	assign sp_wide    = DATA_W'(sp_q);

	// The first operand sits one entry below the top.
	assign raddr = (state_q == S_RD_B) ? ADDR_W'(sp_q - SP_W'(2)) : ADDR_W'(sp_q - SP_W'(1));
	assign we    = ((state_q == S_PUSH) && (err_q == ST_OK) && !stack_full)
		|| (state_q == S_WB);
	assign waddr = (state_q == S_PUSH) ? ADDR_W'(sp_q) : ADDR_W'(sp_q - SP_W'(2));
	assign wdata = (state_q == S_PUSH) ? cmd_q.num : res_q;

	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[waddr] <= wdata;
		end
		rdata_q <= stack_mem[raddr];
	end

	// Restoring division step on magnitudes.
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			err_q     <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_head;
						state_q <= q_head.has_push ? S_PUSH : S_DISP;
					end
				end
				S_PUSH: begin
					if (err_q == ST_OK) begin
						if (stack_full) begin
							err_q <= ST_OVF;
						end else begin
							sp_q <= sp_q + SP_W'(1);
						end
					end
					state_q <= S_DISP;
				end
				S_DISP: begin
					case (cmd_q.kind)
						K_END: begin
							state_q <= (sp_q != '0) ? S_RD_END : S_OUT;
						end
						K_ADD, K_SUB, K_MUL, K_DIV: begin
							if (err_q != ST_OK) begin
								state_q <= S_IDLE;
							end else if (sp_q < SP_W'(2)) begin
								err_q   <= ST_UNDER;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RD_B;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RD_B: begin
					b_q     <= rdata_q;
					state_q <= S_RD_A;
				end
				S_RD_A: begin
					a_q     <= rdata_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (cmd_q.kind)
						K_ADD: begin
							res_q   <= a_q + b_q;
							state_q <= S_WB;
						end
						K_SUB: begin
							res_q   <= a_q - b_q;
							state_q <= S_WB;
						end
						K_MUL: begin
							res_q   <= a_q * b_q;
							state_q <= S_WB;
						end
						default: begin
							if (b_q == '0) begin
								err_q   <= ST_DIVZ;
								state_q <= S_IDLE;
							end else begin
								rem_q   <= '0;
								quo_q   <= a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
								den_q   <= b_q[DATA_W-1] ? (DATA_W'(0) - b_q) : b_q;
								neg_q   <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					rem_q <= fits ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], fits};
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_DFIX;
					end
				end
				S_DFIX: begin
					res_q   <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
					state_q <= S_WB;
				end
				S_WB: begin
					sp_q    <= sp_q - SP_W'(1);
					state_q <= S_IDLE;
				end
				S_RD_END: begin
					res_q   <= rdata_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						value     <= (sp_q != '0) ? res_q : '0;
						if (err_q != ST_OK) begin
							status <= err_q;
						end else if (sp_q == '0) begin
							status <= ST_EMPTY;
						end else begin
							status <= ST_OK;
						end
						depth_left <= (sp_wide > DATA_W'(DEPTH_MAX))
							? DEPTH_OUT_W'(DEPTH_MAX) : sp_wide[DEPTH_OUT_W-1:0];
						sp_q    <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/postfix_integer_evaluator.sv]
// Top level of the postfix integer evaluator.
// Instantiates pie_front, pie_queue and pie_back; depends on pie_pkg.
//
// Usage: characters of a postfix expression enter on the ch channel, one
// word per handshake. Digit runs form unsigned 32-bit numbers; + - * / pop
// two operands and push the result, wrapping to 32 bits, division toward
// zero. Other characters only end a pending number. A NUL character ends
// the expression and produces one result word (value, status, depth_left)
// on the output channel; the stack then clears for the next expression.
// Timing: the front end takes one character per cycle while the four-entry
// command queue has room. The execution unit takes commands only in S_IDLE,
// then S_PUSH for a pending number and S_DISP. + - * go on through S_RD_B,
// S_RD_A, S_EXEC and S_WB; / adds S_DIV (a radix-2 divider producing one
// quotient bit per cycle) and S_DFIX before S_WB; a NUL ends in S_OUT.
// Reset clears the stack pointer, the error state, the queue and the
// partial number. If the receiver stalls, the result register holds its
// word and the block keeps accepting characters until the queue fills.
`timescale 1ns / 1ps

module postfix_integer_evaluator
	import pie_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DATA_W-1:0]      value,
	output logic [2:0]                    status,
	output logic [DEPTH_OUT_W-1:0]        depth_left
);

	logic q_full;
	logic q_push;
	cmd_t q_in;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	pie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	pie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	pie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.status     (status),
		.depth_left (depth_left)
	);

endmodule

[test/pie_result_checker.sv]
// Result checker for the postfix integer evaluator testbench.
// Watches both channels, predicts each result word from the accepted
// characters and compares it field by field. Depends on pie_pkg.
`timescale 1ns / 1ps

module pie_result_checker
	import pie_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [7:0]               ch,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] value,
	input  logic [2:0]               status,
	input  logic [DEPTH_OUT_W-1:0]   depth_left,
	output int                       fail_count,
	output int                       waiting
);

	typedef struct packed {
		logic [DATA_W-1:0]      value;
		logic [2:0]             status;
		logic [DEPTH_OUT_W-1:0] depth;
	} result_t;

	result_t           pending_results[$];
	logic [DATA_W-1:0] operands[STACK_DEPTH];
	logic [SP_W-1:0]   sp = '0;
	logic [DATA_W-1:0] number = '0;
	logic              building = 1'b0;
	logic [2:0]        first_error = ST_OK;
	int                fails = 0;

	// Applies one accepted character to the predicted evaluator state.
	task automatic evaluate_char(input logic [7:0] c);
		logic [DATA_W-1:0] a, b, r, ma, mb, q;
		logic              do_push;
		result_t           res;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			number = number * 10 + (c - CH_ZERO);
			building = 1'b1;
		end else begin
			// Any non-digit ends a pending number.
			if (building && first_error == ST_OK) begin
				if (sp == STACK_DEPTH) begin
					first_error = ST_OVF;
				end else begin
					operands[sp] = number;
					sp++;
				end
			end
			number = '0;
			building = 1'b0;
			if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
				if (first_error == ST_OK) begin
					if (sp < 2) begin
						first_error = ST_UNDER;
					end else begin
						b = operands[sp - 1];
						a = operands[sp - 2];
						do_push = 1'b1;
						r = '0;
						case (c)
							CH_PLUS: begin
								r = a + b;
							end
							CH_MINUS: begin
								r = a - b;
							end
							CH_STAR: begin
								r = a * b;
							end
							default: begin
								if (b == '0) begin
									first_error = ST_DIVZ;
									do_push = 1'b0;
								end else begin
									// Divide magnitudes so the most negative
									// value over -1 simply wraps.
									ma = a[DATA_W-1] ? ('0 - a) : a;
									mb = b[DATA_W-1] ? ('0 - b) : b;
									q = ma / mb;
									r = (a[DATA_W-1] ^ b[DATA_W-1]) ? ('0 - q) : q;
								end
							end
						endcase
						if (do_push) begin
							operands[sp - 2] = r;
							sp--;
						end
					end
				end
			end else if (c == CH_NUL) begin
				res.depth = (sp > DEPTH_MAX) ? DEPTH_OUT_W'(DEPTH_MAX) : DEPTH_OUT_W'(sp);
				res.value = (sp != 0) ? operands[sp - 1] : '0;
				if (first_error != ST_OK)
					res.status = first_error;
				else if (sp == 0)
					res.status = ST_EMPTY;
				else
					res.status = ST_OK;
				pending_results.push_back(res);
				sp = '0;
				first_error = ST_OK;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pending_results.delete();
			sp = '0;
			number = '0;
			building = 1'b0;
			first_error = ST_OK;
			fails = 0;
			fail_count <= 0;
			waiting <= 0;
		end else begin
			// A result word can never come from a character taken at the
			// same edge, so the output side is checked first.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word: value %0d status %0d depth %0d",
						$time, value, status, depth_left);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (value !== want.value) begin
						$display("%0t: value mismatch: expected %0d, actual %0d",
							$time, $signed(want.value), value);
						fails++;
					end
					if (status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, status);
						fails++;
					end
					if (depth_left !== want.depth) begin
						$display("%0t: depth_left mismatch: expected %0d, actual %0d",
							$time, want.depth, depth_left);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				evaluate_char(ch);
			fail_count <= fails;
			waiting <= pending_results.size();
		end
	end

endmodule

[test/postfix_integer_evaluator_tb.sv]
// Testbench top for the postfix integer evaluator.
// Drives expressions character by character with random idling on both
// sides; pie_result_checker does the checking. Depends on pie_pkg.
`timescale 1ns / 1ps

module postfix_integer_evaluator_tb;
	import pie_pkg::*;

	localparam int RANDOM_CHARS = 1100;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 64;
	localparam logic [7:0] OPERATORS[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [7:0]               ch = 8'h00;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] value;
	logic [2:0]               status;
	logic [DEPTH_OUT_W-1:0]   depth_left;
	int                       fail_count;
	int                       waiting;

	int                       send_idle_pct = 20;
	int                       recv_idle_pct = 58;
	int                       chars_sent = 0;
	int unsigned              cycle_count = 0;
	logic [7:0]               expr_text[$];

	postfix_integer_evaluator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.status(status),
		.depth_left(depth_left)
	);

	pie_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.status(status),
		.depth_left(depth_left),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Sends the built text followed by the NUL that closes the expression.
	task automatic send_expression();
		foreach (expr_text[i])
			send_char(expr_text[i]);
		send_char(CH_NUL);
		expr_text.delete();
	endtask

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++)
			expr_text.push_back(s[i]);
	endtask

	task automatic add_separator();
		logic [7:0] c;
		if ($urandom_range(0, 4) != 0) begin
			c = " ";
		end else begin
			do
				c = 8'($urandom_range(1, 255));
			while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
				|| c == CH_STAR || c == CH_SLASH);
		end
		expr_text.push_back(c);
	endtask

	task automatic add_number(input bit sloppy);
		int unsigned n;
		if (sloppy && $urandom_range(0, 9) < 3) begin
			expr_text.push_back(CH_ZERO);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(0, 9);
					add_string($sformatf("%0d", n));
				end
				4, 5: begin
					n = $urandom_range(0, 9999);
					add_string($sformatf("%0d", n));
				end
				6, 7: begin
					n = $urandom();
					add_string($sformatf("%0d", n));
				end
				8: begin
					n = $urandom_range(0, 99);
					add_string($sformatf("00%0d", n));
				end
				default: begin
					// Long digit runs make the accumulator wrap.
					repeat ($urandom_range(11, 20))
						expr_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
				end
			endcase
		end
	endtask

	task automatic add_operator();
		if ($urandom_range(0, 3) == 0)
			add_separator();
		expr_text.push_back(OPERATORS[$urandom_range(0, 3)]);
	endtask

	// A sloppy expression may apply operators with too few operands and
	// favors zero divisors.
	task automatic build_expression(input bit sloppy);
		int depth;
		int steps;
		bit after_number;
		depth = 0;
		after_number = 1'b0;
		steps = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
		repeat (steps) begin
			if ((depth >= 2 || (sloppy && $urandom_range(0, 3) == 0))
				&& $urandom_range(0, 1) == 1) begin
				add_operator();
				if (depth >= 2)
					depth--;
				after_number = 1'b0;
			end else begin
				if (after_number || $urandom_range(0, 5) == 0)
					add_separator();
				add_number(sloppy);
				depth++;
				after_number = 1'b1;
			end
		end
		if ($urandom_range(0, 4) != 0) begin
			while (depth > 1) begin
				add_operator();
				depth--;
			end
		end
	endtask

	task automatic build_deep_stack();
		int n;
		n = ($urandom_range(0, 2) == 0) ? STACK_DEPTH : $urandom_range(55, 70);
		for (int i = 0; i < n; i++) begin
			if (i != 0)
				add_separator();
			expr_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
		end
		repeat ($urandom_range(0, 4))
			add_operator();
	endtask

	initial begin
		string directed[$];
		int pick;
		directed = '{
			"",
			"4294967295 1 +",
			"99999999999",
			"12 30 +",
			"7 12 -",
			"65536 65536 *",
			"123456 7890 *",
			"7 2 /",
			"0 7 - 2 /",
			"7 0 2 - /",
			"0 7 - 0 2 - /",
			"0 2147483648 - 0 1 - /",
			"1 +",
			"+",
			"5 0 /",
			"1 + 5 0 /",
			"5 0 / 3 4 +",
			"3 4",
			"0042x9a!7~",
			"2 3 4 * +",
			"1\3772\200+",
			"8 4 - 3 / 5 /"
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			add_string(directed[i]);
			send_expression();
		end
		// A stack filled exactly to the top, then one word past it.
		for (int i = 1; i <= STACK_DEPTH; i++)
			add_string($sformatf("%0d ", i));
		send_expression();
		for (int i = 1; i <= STACK_DEPTH + 1; i++)
			add_string($sformatf("%0d ", i));
		add_string("+");
		send_expression();

		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			case (chars_sent * 3 / RANDOM_CHARS)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct <= 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct <= 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				build_expression(1'b0);
			end else if (pick < 73) begin
				build_deep_stack();
			end else if (pick < 88) begin
				build_expression(1'b1);
			end else begin
				repeat ($urandom_range(1, 12))
					expr_text.push_back(8'($urandom_range(1, 255)));
			end
			send_expression();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
